// File: hdl/mrrs_pkg.sv
package mrrs_pkg;

  // input opcodes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_PUSH      = 2'd1;
  localparam logic [1:0] OP_SET_READY = 2'd2;
  localparam logic [1:0] OP_NOP       = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_READY = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // configuration register indexes
  localparam logic REG_QUANTUM     = 1'b0;
  localparam logic REG_ACTIVE_CPUS = 1'b1;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;
  localparam logic [2:0]  ACTIVE_RESET  = 3'd4;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  typedef struct packed {
    logic load;
    logic push_step;
    logic push_commit;
    logic tick;
    logic scan_rd;
    logic scan_chk;
    logic set_ready;
    logic rd_cur;
  } cmd_t;

  typedef struct packed {
    logic cpu_ok;
    logic push_last;
    logic tick_due;
    logic scan_hit;
    logic scan_last;
  } stat_t;

endpackage

// File: hdl/mrrs_ram.sv
module mrrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/mrrs_ctrl.sv
module mrrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           opcode,
  input  mrrs_pkg::stat_t      stat,
  output mrrs_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PSCAN   = 4'd1;
  localparam logic [3:0] S_PCOMMIT = 4'd2;
  localparam logic [3:0] S_TICK    = 4'd3;
  localparam logic [3:0] S_SCANRD  = 4'd4;
  localparam logic [3:0] S_SCANCHK = 4'd5;
  localparam logic [3:0] S_SETRDY  = 4'd6;
  localparam logic [3:0] S_RDCUR   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (opcode)
            mrrs_pkg::OP_PUSH:      state_next = S_PSCAN;
            mrrs_pkg::OP_TICK:      state_next = stat.cpu_ok ? S_TICK : S_DONE;
            mrrs_pkg::OP_SET_READY: state_next = stat.cpu_ok ? S_SETRDY : S_DONE;
            mrrs_pkg::OP_NOP:       state_next = stat.cpu_ok ? S_RDCUR : S_DONE;
          endcase
        end
      end
      S_PSCAN: begin
        cmd.push_step = 1'b1;
        if (stat.push_last) begin
          state_next = S_PCOMMIT;
        end
      end
      S_PCOMMIT: begin
        cmd.push_commit = 1'b1;
        state_next      = S_RDCUR;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = stat.tick_due ? S_SCANRD : S_RDCUR;
      end
      S_SCANRD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCANCHK;
      end
      S_SCANCHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = (stat.scan_hit || stat.scan_last) ? S_RDCUR : S_SCANRD;
      end
      S_SETRDY: begin
        cmd.set_ready = 1'b1;
        state_next    = S_RDCUR;
      end
      S_RDCUR: begin
        cmd.rd_cur = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// File: hdl/mrrs_dp.sv
module mrrs_dp #(
  parameter int NUM_CPUS  = 4,
  parameter int MAX_TASKS = 16,
  parameter int ID_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mrrs_pkg::cmd_t       cmd,
  output mrrs_pkg::stat_t      stat,
  input  logic [1:0]           opcode,
  input  logic [1:0]           cpu_index,
  input  logic [3:0]           slot_index,
  input  logic                 ready_flag,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output logic [1:0]           status,
  output logic                 switched,
  output logic [1:0]           placed_cpu,
  output logic [3:0]           placed_slot,
  output logic [15:0]          new_task_id,
  output logic [3:0]           current_slot_out,
  output logic [15:0]          current_task_id
);

  localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SW    = $clog2(MAX_TASKS);
  localparam int NW    = $clog2(MAX_TASKS + 1);
  localparam int AW    = CW + SW;
  localparam int DEPTH = 1 << AW;
  localparam int CXW   = (CW > 2) ? CW : 2;
  localparam int SXW   = (SW > 4) ? SW : 4;

  logic [NW-1:0]       task_count   [NUM_CPUS];
  logic [SW-1:0]       current_slot [NUM_CPUS];
  logic [15:0]         tick_count   [NUM_CPUS];
  logic [NUM_CPUS-1:0] slot0_ready;
  logic [ID_WIDTH-1:0] last_task_id;
  logic [15:0]         quantum;
  logic [2:0]          active_cpus;

  logic [CW-1:0] cpu_sel;
  logic [CW-1:0] best;
  logic [NW-1:0] best_cnt;
  logic [NW-1:0] scan_k;
  logic [SW-1:0] scan_p;
  logic [SW-1:0] scan_start;
  logic [SW-1:0] cur_q;
  logic [3:0]    slot_q;
  logic          rflag_q;

  logic [1:0]  status_q;
  logic        switched_q;
  logic [1:0]  placed_cpu_q;
  logic [3:0]  placed_slot_q;
  logic [15:0] new_id_q;
  logic        cur_valid_q;

  logic [NW-1:0]       cnt_sel;
  logic [SW-1:0]       cur_sel;
  logic [15:0]         tick_sel;
  logic [CW-1:0]       act_last;
  logic [CXW-1:0]      cpu_ext;
  logic [CXW-1:0]      best_ext;
  logic [CW-1:0]       cpu_in;
  logic [SXW-1:0]      slot_ext;
  logic [SW-1:0]       slot_sel;
  logic                slot_ok;
  logic [NW-1:0]       p_plus;
  logic [SW-1:0]       p_next;
  logic                push_full;
  logic [ID_WIDTH-1:0] id_next;
  logic [31:0]         pos32;
  logic [31:0]         nid32;
  logic [31:0]         cur32;
  logic [31:0]         cid32;

  logic                id_we;
  logic [AW-1:0]       id_raddr;
  logic [ID_WIDTH-1:0] id_rdata;
  logic                rdy_we;
  logic [AW-1:0]       rdy_waddr;
  logic                rdy_wdata;
  logic [AW-1:0]       rdy_raddr;
  logic                rdy_rdata;

  assign cnt_sel  = task_count[cpu_sel];
  assign cur_sel  = current_slot[cpu_sel];
  assign tick_sel = tick_count[cpu_sel];

  always_comb begin
    int a;
    a = int'(active_cpus);
    if (a < 1) begin
      a = 1;
    end
    if (a > NUM_CPUS) begin
      a = NUM_CPUS;
    end
    act_last = CW'(a - 1);
  end

  assign cpu_ext  = CXW'(cpu_index);
  assign cpu_in   = cpu_ext[CW-1:0];
  assign best_ext = CXW'(best);
  assign slot_ext = SXW'(slot_q);
  assign slot_sel = slot_ext[SW-1:0];
  assign slot_ok  = 32'(slot_q) < 32'(cnt_sel);

  // forward wrap of the scan pointer over the occupied slots
  assign p_plus = NW'(scan_p) + NW'(1);
  assign p_next = (p_plus >= cnt_sel) ? '0 : p_plus[SW-1:0];

  assign push_full = best_cnt >= NW'(MAX_TASKS);
  assign id_next   = last_task_id + ID_WIDTH'(1);
  assign pos32     = 32'(best_cnt);
  assign nid32     = 32'(id_next);

  assign stat.cpu_ok    = 32'(cpu_index) < 32'(NUM_CPUS);
  assign stat.push_last = (cpu_sel == act_last);
  assign stat.tick_due  = (tick_sel > quantum) && (cnt_sel > NW'(1));
  // slot 0 ready bits live in flops so reset can set them
  assign stat.scan_hit  = (scan_p == '0) ? slot0_ready[cpu_sel] : rdy_rdata;
  assign stat.scan_last = (scan_k == cnt_sel);

  assign id_we     = cmd.push_commit && !push_full;
  assign id_raddr  = {cpu_sel, cur_sel};
  assign rdy_we    = (cmd.push_commit && !push_full) ||
                     (cmd.set_ready && slot_ok && (slot_sel != '0));
  assign rdy_waddr = cmd.push_commit ? {best, best_cnt[SW-1:0]} : {cpu_sel, slot_sel};
  assign rdy_wdata = rflag_q;
  assign rdy_raddr = {cpu_sel, p_next};

  mrrs_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr ({best, best_cnt[SW-1:0]}),
    .wdata (id_next),
    .re    (cmd.rd_cur),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  mrrs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_rdy_ram (
    .clk   (clk),
    .we    (rdy_we),
    .waddr (rdy_waddr),
    .wdata (rdy_wdata),
    .re    (cmd.scan_rd),
    .raddr (rdy_raddr),
    .rdata (rdy_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        task_count[i]   <= NW'(1);
        current_slot[i] <= '0;
        tick_count[i]   <= '0;
      end
      slot0_ready  <= '1;
      last_task_id <= '0;
      quantum      <= mrrs_pkg::QUANTUM_RESET;
      active_cpus  <= mrrs_pkg::ACTIVE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mrrs_pkg::REG_QUANTUM:     quantum     <= cfg_data;
          mrrs_pkg::REG_ACTIVE_CPUS: active_cpus <= cfg_data[2:0];
        endcase
      end
      if (cmd.push_commit && !push_full) begin
        task_count[best] <= best_cnt + NW'(1);
        last_task_id     <= id_next;
      end
      if (cmd.tick) begin
        if (stat.tick_due) begin
          tick_count[cpu_sel] <= '0;
        end else if (tick_sel != mrrs_pkg::TICK_MAX) begin
          tick_count[cpu_sel] <= tick_sel + 16'd1;
        end
      end
      if (cmd.scan_chk && stat.scan_hit) begin
        current_slot[cpu_sel] <= scan_p;
      end
      if (cmd.set_ready && slot_ok && (slot_sel == '0)) begin
        slot0_ready[cpu_sel] <= rflag_q;
      end
    end
  end

  // per-item working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cpu_sel       <= (opcode == mrrs_pkg::OP_PUSH) ? '0 : cpu_in;
      best          <= '0;
      best_cnt      <= '1;
      slot_q        <= slot_index;
      rflag_q       <= ready_flag;
      status_q      <= (!stat.cpu_ok && opcode != mrrs_pkg::OP_PUSH) ?
                       mrrs_pkg::ST_RANGE : mrrs_pkg::ST_OK;
      cur_valid_q   <= stat.cpu_ok || (opcode == mrrs_pkg::OP_PUSH);
      switched_q    <= 1'b0;
      placed_cpu_q  <= cpu_index;
      placed_slot_q <= '0;
      new_id_q      <= '0;
      cur_q         <= '0;
    end
    if (cmd.push_step) begin
      if (cnt_sel < best_cnt) begin
        best     <= cpu_sel;
        best_cnt <= cnt_sel;
      end
      cpu_sel <= cpu_sel + CW'(1);
    end
    if (cmd.push_commit) begin
      cpu_sel      <= best;
      placed_cpu_q <= best_ext[1:0];
      if (push_full) begin
        status_q <= mrrs_pkg::ST_FULL;
      end else begin
        placed_slot_q <= pos32[3:0];
        new_id_q      <= nid32[15:0];
      end
    end
    if (cmd.tick) begin
      scan_p     <= cur_sel;
      scan_start <= cur_sel;
      scan_k     <= '0;
    end
    if (cmd.scan_rd) begin
      scan_p <= p_next;
      scan_k <= scan_k + NW'(1);
    end
    if (cmd.scan_chk) begin
      if (stat.scan_hit) begin
        switched_q <= (scan_p != scan_start);
      end else if (stat.scan_last) begin
        status_q <= mrrs_pkg::ST_NO_READY;
      end
    end
    if (cmd.set_ready && !slot_ok) begin
      status_q <= mrrs_pkg::ST_RANGE;
    end
    if (cmd.rd_cur) begin
      cur_q <= cur_sel;
    end
  end

  assign cur32 = 32'(cur_q);
  assign cid32 = 32'(id_rdata);

  assign status           = status_q;
  assign switched         = switched_q;
  assign placed_cpu       = placed_cpu_q;
  assign placed_slot      = placed_slot_q;
  assign new_task_id      = new_id_q;
  assign current_slot_out = cur_valid_q ? cur32[3:0] : 4'd0;
  // slot 0 is never written by a push and holds id 0
  assign current_task_id  = (cur_valid_q && cur_q != '0) ? cid32[15:0] : 16'd0;

endmodule

// File: hdl/multicore_round_robin_scheduler_unit.sv
// Steps: push searches the active CPUs, then commits and reads the current slot;
// set-ready writes the flag first; no-op only reads; tick may scan for a ready slot.
// Throughput: one item at a time; the next start is taken the cycle after done.
// The least-loaded search walks one CPU a cycle; the ready scan reads, then checks.
// Synchronous reset: slot 0 of each CPU ready with id 0, one task per CPU,
// quantum 10, four active CPUs. The receiver cannot stall: done lasts one cycle.
module multicore_round_robin_scheduler_unit #(
  parameter int NUM_CPUS  = 4,
  parameter int MAX_TASKS = 16,
  parameter int ID_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [1:0]  cpu_index,
  input  logic [3:0]  slot_index,
  input  logic        ready_flag,
  output logic        done,
  output logic [1:0]  status,
  output logic        switched,
  output logic [1:0]  placed_cpu,
  output logic [3:0]  placed_slot,
  output logic [15:0] new_task_id,
  output logic [3:0]  current_slot_out,
  output logic [15:0] current_task_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  mrrs_pkg::cmd_t  cmd;
  mrrs_pkg::stat_t stat;
  logic            item_go;

  assign cfg_ready = 1'b1;
  assign item_go   = start && !busy;

  mrrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (item_go),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mrrs_dp #(
    .NUM_CPUS  (NUM_CPUS),
    .MAX_TASKS (MAX_TASKS),
    .ID_WIDTH  (ID_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .opcode           (opcode),
    .cpu_index        (cpu_index),
    .slot_index       (slot_index),
    .ready_flag       (ready_flag),
    .cfg_we           (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .status           (status),
    .switched         (switched),
    .placed_cpu       (placed_cpu),
    .placed_slot      (placed_slot),
    .new_task_id      (new_task_id),
    .current_slot_out (current_slot_out),
    .current_task_id  (current_task_id)
  );

endmodule
